// ===== sv/deq_pkg.sv =====
package deq_pkg;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned CNT_W       = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned FUNC_W      = 3;
  localparam int unsigned ENTRY_CNT_W = 5;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH_FRONT = 3'd0,
    FUNC_PUSH_BACK  = 3'd1,
    FUNC_POP_FRONT  = 3'd2,
    FUNC_POP_BACK   = 3'd3,
    FUNC_CLEAR      = 3'd4
  } func_e;

  typedef struct packed {
    logic load;
    logic shift_r;
    logic shift_l;
  } cell_ctl_t;

endpackage

// ===== sv/deq_cell.sv =====
module deq_cell (
  input  logic                               clk_i,
  input  deq_pkg::cell_ctl_t                 ctl_i,
  input  logic signed [deq_pkg::DATA_W-1:0]  push_value_i,
  input  logic signed [deq_pkg::DATA_W-1:0]  left_data_i,
  input  logic signed [deq_pkg::DATA_W-1:0]  right_data_i,
  output logic signed [deq_pkg::DATA_W-1:0]  data_o
);

  logic signed [deq_pkg::DATA_W-1:0] data_d, data_q;

  always_comb begin
    data_d = data_q;
    if (ctl_i.load) begin
      data_d = push_value_i;
    end else if (ctl_i.shift_r) begin
      data_d = left_data_i;
    end else if (ctl_i.shift_l) begin
      data_d = right_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ===== sv/double_ended_queue_core.sv =====
// channel  | handshake            | payload
// ---------+----------------------+-------------------------------------------
// item in  | start, busy          | func_i, push_value_i
// item out | valid_o (strobe)     | pop_value_o, error_o, entry_count_o,
//          |                      | is_empty_o
//
// One item per cycle; its result strobes in the cycle after it is accepted.
// The rate is set by the row of cells, which all shift together or load one cell;
// the front sits in cell 0 and the back in the cell just below the count.
// busy stays low. Reset empties the queue at once; cell data is not cleared.
// The receiver cannot stall: each result is shown for one cycle only.
module double_ended_queue_core (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [deq_pkg::FUNC_W-1:0]             func_i,
  input  logic signed [deq_pkg::DATA_W-1:0]      push_value_i,
  output logic                                   valid_o,
  output logic signed [deq_pkg::DATA_W-1:0]      pop_value_o,
  output logic                                   error_o,
  output logic [deq_pkg::ENTRY_CNT_W-1:0]        entry_count_o,
  output logic                                   is_empty_o
);

  logic                               accept;
  logic                               full;
  logic                               empty;
  logic [deq_pkg::CNT_W-1:0]          count_d, count_q;
  logic                               valid_q;
  logic signed [deq_pkg::DATA_W-1:0]  pop_value_d, pop_value_q;
  logic                               error_d, error_q;
  logic signed [deq_pkg::DATA_W-1:0]  back_val;
  logic                               do_shift_r, do_shift_l, do_load_back;
  deq_pkg::cell_ctl_t                 ctl [deq_pkg::DEPTH];
  logic signed [deq_pkg::DATA_W-1:0]  data [deq_pkg::DEPTH];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count_q == deq_pkg::CNT_W'(deq_pkg::DEPTH));
  assign empty  = (count_q == '0);

  // back entry: AND-OR over the row, picked by count
  always_comb begin
    back_val = '0;
    for (int i = 0; i < deq_pkg::DEPTH; i++) begin
      if (count_q == deq_pkg::CNT_W'(i + 1)) begin
        back_val = back_val | data[i];
      end
    end
  end

  always_comb begin
    count_d      = count_q;
    pop_value_d  = '0;
    error_d      = 1'b0;
    do_shift_r   = 1'b0;
    do_shift_l   = 1'b0;
    do_load_back = 1'b0;
    case (deq_pkg::func_e'(func_i))
      deq_pkg::FUNC_PUSH_FRONT: begin
        if (full) begin
          error_d = 1'b1;
        end else begin
          do_shift_r = 1'b1;
          count_d    = count_q + 1'b1;
        end
      end
      deq_pkg::FUNC_PUSH_BACK: begin
        if (full) begin
          error_d = 1'b1;
        end else begin
          do_load_back = 1'b1;
          count_d      = count_q + 1'b1;
        end
      end
      deq_pkg::FUNC_POP_FRONT: begin
        if (empty) begin
          error_d = 1'b1;
        end else begin
          pop_value_d = data[0];
          do_shift_l  = 1'b1;
          count_d     = count_q - 1'b1;
        end
      end
      deq_pkg::FUNC_POP_BACK: begin
        if (empty) begin
          error_d = 1'b1;
        end else begin
          pop_value_d = back_val;
          count_d     = count_q - 1'b1;
        end
      end
      deq_pkg::FUNC_CLEAR: begin
        count_d = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < deq_pkg::DEPTH; i++) begin
      ctl[i].load    = accept && do_load_back && (count_q == deq_pkg::CNT_W'(i));
      ctl[i].shift_r = accept && do_shift_r;
      ctl[i].shift_l = accept && do_shift_l;
    end
  end

  for (genvar g = 0; g < deq_pkg::DEPTH; g++) begin : g_cell
    logic signed [deq_pkg::DATA_W-1:0] left_data;
    logic signed [deq_pkg::DATA_W-1:0] right_data;

    if (g == 0) begin : g_first
      assign left_data = push_value_i;
    end else begin : g_mid_l
      assign left_data = data[g-1];
    end

    if (g == deq_pkg::DEPTH - 1) begin : g_last
      assign right_data = data[g];
    end else begin : g_mid_r
      assign right_data = data[g+1];
    end

    deq_cell u_cell (
      .clk_i        (clk_i),
      .ctl_i        (ctl[g]),
      .push_value_i (push_value_i),
      .left_data_i  (left_data),
      .right_data_i (right_data),
      .data_o       (data[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pop_value_q <= pop_value_d;
      error_q     <= error_d;
    end
  end

  assign valid_o       = valid_q;
  assign pop_value_o   = pop_value_q;
  assign error_o       = error_q;
  assign entry_count_o = deq_pkg::ENTRY_CNT_W'(count_q);
  assign is_empty_o    = (count_q == '0);

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= deq_pkg::CNT_W'(deq_pkg::DEPTH))
    else $error("entry count beyond depth");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> valid_o)
    else $error("item without result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> !valid_o)
    else $error("result without item");

  a_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && empty && (func_i == deq_pkg::FUNC_POP_FRONT ||
                         func_i == deq_pkg::FUNC_POP_BACK))
    |=> (error_o && pop_value_o == '0 && is_empty_o))
    else $error("pop on empty not flagged");

  a_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && full && (func_i == deq_pkg::FUNC_PUSH_FRONT ||
                        func_i == deq_pkg::FUNC_PUSH_BACK))
    |=> (error_o && $stable(count_q)))
    else $error("push on full not flagged");

endmodule

// ===== sim/double_ended_queue_core_tb.sv =====
module double_ended_queue_core_tb;

  localparam logic [deq_pkg::FUNC_W-1:0] FUNC_UNUSED_LO  = 3'd5;
  localparam logic [deq_pkg::FUNC_W-1:0] FUNC_UNUSED_MID = 3'd6;
  localparam logic [deq_pkg::FUNC_W-1:0] FUNC_UNUSED_HI  = 3'd7;
  localparam int ITEMS_PER_PHASE = 175;
  localparam int NUM_DIR_ROWS    = 16;
  localparam int IDX_W           = $clog2(deq_pkg::DEPTH);

  typedef struct packed {
    logic signed [deq_pkg::DATA_W-1:0] pop_value;
    logic                              error;
    logic [deq_pkg::ENTRY_CNT_W-1:0]   count;
    logic                              empty;
  } deq_result_t;

  typedef struct {
    logic [deq_pkg::FUNC_W-1:0]        f;
    logic signed [deq_pkg::DATA_W-1:0] v;
    bit                                rand_value;
    int                                reps;
    bit                                typed;
    logic signed [deq_pkg::DATA_W-1:0] e_pop;
    logic                              e_err;
    logic [deq_pkg::ENTRY_CNT_W-1:0]   e_cnt;
    logic                              e_empty;
  } dir_row_t;

  logic                              clk_i;
  logic                              rst_ni;
  logic                              start;
  logic                              busy;
  logic [deq_pkg::FUNC_W-1:0]        func_i;
  logic signed [deq_pkg::DATA_W-1:0] push_value_i;
  logic                              valid_o;
  logic signed [deq_pkg::DATA_W-1:0] pop_value_o;
  logic                              error_o;
  logic [deq_pkg::ENTRY_CNT_W-1:0]   entry_count_o;
  logic                              is_empty_o;

  logic signed [deq_pkg::DATA_W-1:0] model_mem [deq_pkg::DEPTH];
  int unsigned                       model_front;
  int unsigned                       model_count;
  deq_result_t                       pending_results [$];
  int                                mismatch_count;

  dir_row_t dir_rows [NUM_DIR_ROWS] = '{
    '{deq_pkg::FUNC_POP_FRONT,  32'sh0,        1'b0, 1, 1'b1, 32'sh0,        1'b1, 5'd0,
      1'b1},
    '{deq_pkg::FUNC_POP_BACK,   32'sh0,        1'b0, 1, 1'b1, 32'sh0,        1'b1, 5'd0,
      1'b1},
    '{FUNC_UNUSED_LO,           32'sh0,        1'b0, 1, 1'b1, 32'sh0,        1'b0, 5'd0,
      1'b1},
    '{deq_pkg::FUNC_PUSH_FRONT, 32'sh7fffffff, 1'b0, 1, 1'b1, 32'sh0,        1'b0, 5'd1,
      1'b0},
    '{deq_pkg::FUNC_PUSH_BACK,  32'sh80000000, 1'b0, 1, 1'b1, 32'sh0,        1'b0, 5'd2,
      1'b0},
    '{deq_pkg::FUNC_PUSH_FRONT, -32'sd1,       1'b0, 1, 1'b1, 32'sh0,        1'b0, 5'd3,
      1'b0},
    '{deq_pkg::FUNC_POP_BACK,   32'sh0,        1'b0, 1, 1'b1, 32'sh80000000, 1'b0, 5'd2,
      1'b0},
    '{deq_pkg::FUNC_POP_FRONT,  32'sh0,        1'b0, 1, 1'b1, -32'sd1,       1'b0, 5'd1,
      1'b0},
    '{deq_pkg::FUNC_CLEAR,      32'sh0,        1'b0, 1, 1'b1, 32'sh0,        1'b0, 5'd0,
      1'b1},
    '{deq_pkg::FUNC_PUSH_FRONT, 32'sh0,        1'b1, 9, 1'b0, 32'sh0,        1'b0, 5'd0,
      1'b0},
    '{deq_pkg::FUNC_PUSH_BACK,  32'sh0,        1'b1, 7, 1'b0, 32'sh0,        1'b0, 5'd0,
      1'b0},
    '{deq_pkg::FUNC_PUSH_FRONT, 32'sh0,        1'b0, 1, 1'b1, 32'sh0,        1'b1, 5'd16,
      1'b0},
    '{deq_pkg::FUNC_PUSH_BACK,  32'sh1,        1'b0, 1, 1'b1, 32'sh0,        1'b1, 5'd16,
      1'b0},
    '{deq_pkg::FUNC_POP_BACK,   32'sh0,        1'b0, 3, 1'b0, 32'sh0,        1'b0, 5'd0,
      1'b0},
    '{deq_pkg::FUNC_POP_FRONT,  32'sh0,        1'b0, 2, 1'b0, 32'sh0,        1'b0, 5'd0,
      1'b0},
    '{deq_pkg::FUNC_CLEAR,      32'sh0,        1'b0, 1, 1'b1, 32'sh0,        1'b0, 5'd0,
      1'b1}
  };

  double_ended_queue_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .func_i        (func_i),
    .push_value_i  (push_value_i),
    .valid_o       (valid_o),
    .pop_value_o   (pop_value_o),
    .error_o       (error_o),
    .entry_count_o (entry_count_o),
    .is_empty_o    (is_empty_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic deq_result_t apply_deque_op(logic [deq_pkg::FUNC_W-1:0] f,
                                                 logic signed [deq_pkg::DATA_W-1:0] v);
    deq_result_t r;
    r = '0;
    case (f)
      deq_pkg::FUNC_PUSH_FRONT: begin
        if (model_count >= deq_pkg::DEPTH) begin
          r.error = 1'b1;
        end else begin
          model_front = (model_front + deq_pkg::DEPTH - 1) % deq_pkg::DEPTH;
          model_mem[IDX_W'(model_front)] = v;
          model_count++;
        end
      end
      deq_pkg::FUNC_PUSH_BACK: begin
        if (model_count >= deq_pkg::DEPTH) begin
          r.error = 1'b1;
        end else begin
          model_mem[IDX_W'((model_front + model_count) % deq_pkg::DEPTH)] = v;
          model_count++;
        end
      end
      deq_pkg::FUNC_POP_FRONT: begin
        if (model_count == 0) begin
          r.error = 1'b1;
        end else begin
          r.pop_value = model_mem[IDX_W'(model_front)];
          model_front = (model_front + 1) % deq_pkg::DEPTH;
          model_count--;
        end
      end
      deq_pkg::FUNC_POP_BACK: begin
        if (model_count == 0) begin
          r.error = 1'b1;
        end else begin
          r.pop_value =
            model_mem[IDX_W'((model_front + model_count - 1) % deq_pkg::DEPTH)];
          model_count--;
        end
      end
      deq_pkg::FUNC_CLEAR: begin
        model_front = 0;
        model_count = 0;
      end
      default: ;
    endcase
    r.count = deq_pkg::ENTRY_CNT_W'(model_count);
    r.empty = (model_count == 0);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0h, want %0h", what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin
    deq_result_t want;
    if (rst_ni && valid_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected item", longint'(pop_value_o), 64'sd0);
      end else begin
        want = pending_results.pop_front();
        if (pop_value_o !== want.pop_value)
          report_mismatch("pop_value", longint'(pop_value_o), longint'(want.pop_value));
        if (error_o !== want.error)
          report_mismatch("error", longint'(error_o), longint'(want.error));
        if (entry_count_o !== want.count)
          report_mismatch("entry_count", longint'(entry_count_o), longint'(want.count));
        if (is_empty_o !== want.empty)
          report_mismatch("is_empty", longint'(is_empty_o), longint'(want.empty));
      end
    end
  end

  task automatic send_item(logic [deq_pkg::FUNC_W-1:0] f,
                           logic signed [deq_pkg::DATA_W-1:0] v,
                           bit typed, deq_result_t typed_res);
    deq_result_t r;
    @(negedge clk_i);
    start        <= 1'b1;
    func_i       <= f;
    push_value_i <= v;
    do @(posedge clk_i); while (busy);
    r = apply_deque_op(f, v);
    pending_results.push_back(typed ? typed_res : r);
  endtask

  task automatic idle_for(int n);
    if (n > 0) begin
      @(negedge clk_i);
      start        <= 1'b0;
      func_i       <= deq_pkg::FUNC_W'($urandom);
      push_value_i <= $urandom;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  function automatic logic [deq_pkg::FUNC_W-1:0] pick_func(int push_bias);
    int r;
    r = $urandom_range(99);
    if (r < 2) return deq_pkg::FUNC_CLEAR;
    if (r < 5) begin
      case ($urandom_range(2))
        0: return FUNC_UNUSED_LO;
        1: return FUNC_UNUSED_MID;
        default: return FUNC_UNUSED_HI;
      endcase
    end
    if ($urandom_range(99) < push_bias)
      return $urandom_range(1) ? deq_pkg::FUNC_PUSH_BACK : deq_pkg::FUNC_PUSH_FRONT;
    return $urandom_range(1) ? deq_pkg::FUNC_POP_BACK : deq_pkg::FUNC_POP_FRONT;
  endfunction

  function automatic logic signed [deq_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'sh0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int idle_pct [4];
    int push_bias;
    int regime_left;
    logic signed [deq_pkg::DATA_W-1:0] v;
    deq_result_t typed_res;

    idle_pct       = '{0, 75, 0, 28};
    rst_ni         = 1'b0;
    start          = 1'b0;
    func_i         = '0;
    push_value_i   = '0;
    model_front    = 0;
    model_count    = 0;
    mismatch_count = 0;
    foreach (model_mem[k]) model_mem[k] = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) begin
      typed_res = {dir_rows[i].e_pop, dir_rows[i].e_err, dir_rows[i].e_cnt,
                   dir_rows[i].e_empty};
      for (int j = 0; j < dir_rows[i].reps; j++) begin
        v = dir_rows[i].rand_value ? $urandom : dir_rows[i].v;
        send_item(dir_rows[i].f, v, dir_rows[i].typed, typed_res);
      end
    end

    // mix fill-heavy, drain-heavy and balanced stretches so the queue hits full and empty
    regime_left = 0;
    push_bias   = 50;
    for (int phase = 0; phase < 4; phase++) begin
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (regime_left == 0) begin
          regime_left = $urandom_range(10, 40);
          case ($urandom_range(2))
            0: push_bias = 85;
            1: push_bias = 15;
            default: push_bias = 50;
          endcase
        end
        regime_left--;
        send_item(pick_func(push_bias), pick_value(), 1'b0, '0);
        while ($urandom_range(99) < idle_pct[phase]) idle_for(1);
      end
    end

    @(negedge clk_i);
    start <= 1'b0;
    for (int k = 0; k < 200 && pending_results.size() != 0; k++) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (pending_results.size() != 0)
      report_mismatch("items never returned", longint'(pending_results.size()), 64'sd0);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Mismatches found");
    $finish;
  end

endmodule
